>>> src/cslc_pkg.sv
// Shared types and codes for the charge status LED controller.
package cslc_pkg;

   // Width of the blink phase counters (holds twice the largest tick rate).
   localparam int PHASE_W = 7;
   // Width of a battery percentage or threshold.
   localparam int PCT_W = 7;
   // Reset value of the low battery threshold.
   localparam logic [PCT_W-1:0] LOW_PCT_RESET = 7'd10;

   // Operation codes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_MANUAL = 1'b1;

   // Charge state codes.
   localparam logic [2:0] CS_CHARGE      = 3'd0;
   localparam logic [2:0] CS_DISCHARGE   = 3'd1;
   localparam logic [2:0] CS_ERROR       = 3'd2;
   localparam logic [2:0] CS_NEAR_FULL   = 3'd3;
   localparam logic [2:0] CS_IDLE        = 3'd4;
   localparam logic [2:0] CS_FORCED_IDLE = 3'd5;
   localparam logic [2:0] CS_OTHER       = 3'd6;

   // Active charge port codes.
   localparam logic [1:0] PORT_NONE = 2'd0;
   localparam logic [1:0] PORT_ZERO = 2'd1;
   localparam logic [1:0] PORT_ONE  = 2'd2;

   // LED colour, encoded as the {white, amber} line pair.
   typedef enum logic [1:0] {
      COL_OFF   = 2'b00,
      COL_AMBER = 2'b01,
      COL_WHITE = 2'b10
   } colour_type;

   // One input beat.
   typedef struct packed {
      logic             op;
      logic [2:0]       chg_state;
      logic             in_suspend;
      logic [PCT_W-1:0] battery_percent;
      logic [1:0]       active_port;
      logic             auto_left;
      logic             auto_right;
      logic             led_select;
      logic             want_white;
      logic             want_amber;
   } req_payload_type;

   // One result beat.
   typedef struct packed {
      logic amber_zero;
      logic white_zero;
      logic amber_one;
      logic white_one;
   } rsp_payload_type;

   // Block state carried from one item to the next.
   typedef struct packed {
      logic [PHASE_W-1:0] battery_phase;
      logic [PHASE_W-1:0] suspend_phase;
      logic [1:0]         led_zero;
      logic [1:0]         led_one;
   } state_type;

endpackage

>>> src/cslc_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface cslc_req_if;
   import cslc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cslc_rsp_if;
   import cslc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cslc_csr_if;
   import cslc_pkg::*;
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/cslc_update.sv
// Next-state logic: phase counters and LED line selection for one beat.
module cslc_update #(
   parameter int TICKS_PER_SEC  = 5,
   parameter int TICKS_HALF_SEC = 2
) (
   input  cslc_pkg::req_payload_type          item,
   input  cslc_pkg::state_type                cur,
   input  logic [cslc_pkg::PCT_W-1:0]         low_pct,
   output cslc_pkg::state_type                nxt
);
   import cslc_pkg::*;

   localparam logic [PHASE_W-1:0] TPS       = PHASE_W'(TICKS_PER_SEC);
   localparam logic [PHASE_W-1:0] HALF      = PHASE_W'(TICKS_HALF_SEC);
   localparam logic [PHASE_W-1:0] PERIOD_M1 = PHASE_W'(2 * TICKS_PER_SEC - 1);

   logic [PHASE_W-1:0] bp_inc;
   logic [PHASE_W-1:0] sp_inc;
   logic [PHASE_W-1:0] bp_mod;
   logic               suspend_path;
   colour_type         manual_col;
   colour_type         blink_col;
   colour_type         low_col;
   colour_type         err_col;
   colour_type         susp_col;

   // Phases wrap at twice the tick rate; a phase never reaches the period.
   assign bp_inc = (cur.battery_phase == PERIOD_M1) ? '0 : cur.battery_phase + 1'b1;
   assign sp_inc = (cur.suspend_phase == PERIOD_M1) ? '0 : cur.suspend_phase + 1'b1;
   // Phase below twice the rate, so one conditional subtract gives the remainder.
   assign bp_mod = (bp_inc >= TPS) ? bp_inc - TPS : bp_inc;

   assign suspend_path = item.in_suspend && (item.chg_state != CS_CHARGE);

   // Colour candidates for the different display modes.
   assign manual_col = item.want_white ? COL_WHITE : (item.want_amber ? COL_AMBER : COL_OFF);
   assign blink_col  = (bp_inc < TPS) ? COL_AMBER : COL_OFF;
   assign low_col    = (item.battery_percent <= low_pct) ? blink_col : COL_OFF;
   assign err_col    = (bp_mod < HALF) ? COL_AMBER : COL_OFF;
   assign susp_col   = (sp_inc < TPS) ? COL_WHITE : COL_OFF;

   // Select the new lines and phases.
   always_comb begin
      nxt = cur;
      if (item.op == OP_MANUAL) begin
         if (item.led_select) begin
            nxt.led_one = manual_col;
         end else begin
            nxt.led_zero = manual_col;
         end
      end else begin
         nxt.battery_phase = bp_inc;
         if (suspend_path) begin
            nxt.suspend_phase = sp_inc;
            nxt.led_zero      = susp_col;
            nxt.led_one       = susp_col;
         end else begin
            nxt.suspend_phase = '0;
            unique case (item.chg_state) inside
               CS_CHARGE: begin
                  if (item.auto_left) begin
                     nxt.led_zero = (item.active_port == PORT_ZERO) ? COL_AMBER : COL_OFF;
                  end
                  if (item.auto_right) begin
                     nxt.led_one = (item.active_port == PORT_ONE) ? COL_AMBER : COL_OFF;
                  end
               end
               CS_DISCHARGE: begin
                  if (item.auto_left) begin
                     nxt.led_zero = low_col;
                  end
                  if (item.auto_right) begin
                     nxt.led_one = low_col;
                  end
               end
               CS_ERROR: begin
                  if (item.auto_left) begin
                     nxt.led_zero = err_col;
                  end
                  if (item.auto_right) begin
                     nxt.led_one = err_col;
                  end
               end
               CS_NEAR_FULL, CS_IDLE: begin
                  if (item.auto_left) begin
                     nxt.led_zero = (item.active_port == PORT_ZERO) ? COL_WHITE : COL_OFF;
                  end
                  if (item.auto_right) begin
                     nxt.led_one = (item.active_port == PORT_ONE) ? COL_WHITE : COL_OFF;
                  end
               end
               CS_FORCED_IDLE: begin
                  if (item.auto_left) begin
                     nxt.led_zero = (item.active_port == PORT_ZERO) ? blink_col : COL_OFF;
                  end
                  if (item.auto_right) begin
                     nxt.led_one = (item.active_port == PORT_ONE) ? blink_col : COL_OFF;
                  end
               end
               default: begin
                  // Other and unused states leave the lines as they are.
                  nxt.led_zero = cur.led_zero;
               end
            endcase
         end
      end
   end

endmodule

>>> src/cslc_skid.sv
// Two-entry result buffer that decouples the result channel from the input side.
module cslc_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  cslc_pkg::rsp_payload_type push_data,
   cslc_rsp_if.source                rsp
);
   import cslc_pkg::*;

   logic [1:0]      count_ff, count_in;
   rsp_payload_type head_ff, head_in;
   rsp_payload_type tail_ff, tail_in;
   logic            push;
   logic            pop;

   assign push_ready = (count_ff != 2'd2);
   assign push       = push_valid && push_ready;
   assign pop        = rsp.valid && rsp.ready;
   assign rsp.valid  = (count_ff != 2'd0);
   assign rsp.data   = head_ff;

   // Head holds the oldest beat, tail the one behind it.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

>>> src/charge_status_led_controller_core.sv
// Top level of the charge status LED controller.
//
// Channels: req_bus takes tick and manual beats, rsp_bus returns one beat per
// request holding the four LED lines after that request, and csr_bus writes
// the low battery threshold (always ready; write only while idle).
// Throughput: one request per cycle while the result buffer has space. The
// phase counters and LED lines are registered when a request is accepted,
// and the next request sees the new state from that register, so this state
// loop sets the rate of one beat per cycle.
// The result for a request is registered in the result buffer when it is
// accepted and is shown on rsp_bus from the head of that buffer.
// A two-entry result buffer sits before rsp_bus: while the receiver stalls,
// requests are still taken until both entries are full, then req_bus.ready
// drops until a result is taken.
// Reset clears the phases and turns all LEDs off, empties the result buffer
// and sets the threshold to ten percent.
module charge_status_led_controller_core #(
   parameter int TICKS_PER_SEC  = 5,
   parameter int TICKS_HALF_SEC = 2
) (
   input  logic        clock,
   input  logic        reset,
   cslc_req_if.sink    req_bus,
   cslc_rsp_if.source  rsp_bus,
   cslc_csr_if.sink    csr_bus
);
   import cslc_pkg::*;

   state_type        state_ff, state_in;
   state_type        upd_state;
   logic [PCT_W-1:0] low_pct_ff, low_pct_in;
   logic             buf_ready;
   logic             accept;
   rsp_payload_type  result;

   // Threshold register write port.
   assign csr_bus.ready = 1'b1;
   assign low_pct_in    = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : low_pct_ff;

   // Request acceptance follows buffer space.
   assign req_bus.ready = buf_ready;
   assign accept        = req_bus.valid && buf_ready;

   cslc_update #(
      .TICKS_PER_SEC  (TICKS_PER_SEC),
      .TICKS_HALF_SEC (TICKS_HALF_SEC)
   ) u_update (
      .item    (req_bus.data),
      .cur     (state_ff),
      .low_pct (low_pct_ff),
      .nxt     (upd_state)
   );

   assign state_in = accept ? upd_state : state_ff;

   // Result beat is the line state after this request.
   assign result.amber_zero = upd_state.led_zero[0];
   assign result.white_zero = upd_state.led_zero[1];
   assign result.amber_one  = upd_state.led_one[0];
   assign result.white_one  = upd_state.led_one[1];

   cslc_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_bus.valid),
      .push_ready (buf_ready),
      .push_data  (result),
      .rsp        (rsp_bus)
   );

   // State and threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         low_pct_ff <= LOW_PCT_RESET;
      end else begin
         state_ff   <= state_in;
         low_pct_ff <= low_pct_in;
      end
   end

endmodule

>>> src/cslc_checker.sv
// Port-level checks for the charge status LED controller, bound to the top.
module cslc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input cslc_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input cslc_pkg::rsp_payload_type rsp_data
);
   import cslc_pkg::*;

   // The cycle after reset no result is shown.
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // An LED never lights both colours.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.amber_zero && rsp_data.white_zero)
                 && !(rsp_data.amber_one && rsp_data.white_one))
      else $error("LED shows amber and white together");

   // A manual white on LED zero into an empty output appears next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && (req_data.op == OP_MANUAL)
         && !req_data.led_select && req_data.want_white
      |=> rsp_valid && rsp_data.white_zero && !rsp_data.amber_zero)
      else $error("manual white on LED zero not shown");

endmodule

bind charge_status_led_controller_core cslc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_data  (req_bus.data),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
